>>> rtl/core/rvm_pkg.sv
// Shared types and constants for the register VM instruction executor.
`default_nettype none

package rvm_pkg;

    // Register file geometry and datapath widths.
    localparam int NUM_REGS  = 32;
    localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DATA_W    = 64;
    localparam int FIELD_W   = 16;
    localparam int OUT_IDX_W = 5;
    localparam int ALU_W     = DATA_W + 2;
    localparam int CNT_W     = $clog2(DATA_W);

    // Opcodes carried in the mode field.
    typedef enum logic [3:0] {
        OP_CONST = 4'd0,
        OP_MOVE  = 4'd1,
        OP_JUMP  = 4'd2,
        OP_JNLT  = 4'd3,
        OP_JNEQ  = 4'd4,
        OP_ADD   = 4'd5,
        OP_REM   = 4'd6,
        OP_NOP   = 4'd7,
        OP_END   = 4'd8
    } op_t;

    // Status codes reported with each result word.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_ABSY,
        S_STEP,
        S_SIGN,
        S_FINISH
    } state_t;

    // Register file read request.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr0;
        logic [REG_IDX_W-1:0] addr1;
    } rf_rd_t;

    // Register file write request.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } rf_wr_t;

    // Register file read data.
    typedef struct packed {
        logic [DATA_W-1:0] data0;
        logic [DATA_W-1:0] data1;
    } rf_rdata_t;

endpackage

`default_nettype wire

>>> rtl/core/register_vm_instruction_executor.sv
// Top level of the register VM instruction executor: sequencer, shared adder, result register.
//
//  Channel | Handshake          | Word
//  --------+--------------------+---------------------------------------------------------
//  in      | in_valid, in_stall | mode, field_a, field_b, field_c
//  out     | out_valid, out_stall | pc_delta, halted, write_enable, write_index,
//          |                    | write_value, status
//
// Each instruction passes through accept, register read, execute, and result load
// before the next word is accepted. A remainder adds the one-bit-per-cycle restoring
// division on the shared 66-bit adder (64 steps plus two sign fixups).
// The input is stalled while an instruction is in flight; a finished result may wait in the
// output register while the next word is accepted.
// Reset clears the sequencer, the output valid and the register file valid bits, so every
// register reads as zero until written. Output stall holds the sequencer in its last state.
`default_nettype none

module register_vm_instruction_executor
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [3:0]           mode,
    input  wire logic signed [15:0]   field_a,
    input  wire logic signed [63:0]   field_b,
    input  wire logic signed [15:0]   field_c,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [15:0]        pc_delta,
    output logic                      halted,
    output logic                      write_enable,
    output logic [4:0]                write_index,
    output logic signed [63:0]        write_value,
    output logic [1:0]                status
);

    localparam int DW = rvm_pkg::DATA_W;
    localparam int FW = rvm_pkg::FIELD_W;
    localparam int AW = rvm_pkg::ALU_W;
    localparam int IW = rvm_pkg::REG_IDX_W;
    localparam int OW = rvm_pkg::OUT_IDX_W;
    localparam int CW = rvm_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

    rvm_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    logic [3:0]      mode_reg, mode_next;
    logic [FW-1:0]   a_reg, a_next;
    logic [DW-1:0]   b_reg, b_next;
    logic [FW-1:0]   c_reg, c_next;
    logic            neg_reg, neg_next;
    logic [DW-1:0]   num_reg, num_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    logic [FW-1:0]   res_delta_reg, res_delta_next;
    logic            res_halt_reg, res_halt_next;
    logic            res_we_reg, res_we_next;
    logic [OW-1:0]   res_idx_reg, res_idx_next;
    logic [DW-1:0]   res_val_reg, res_val_next;
    logic [1:0]      res_status_reg, res_status_next;

    logic [FW-1:0]   o_delta_reg, o_delta_next;
    logic            o_halt_reg, o_halt_next;
    logic            o_we_reg, o_we_next;
    logic [OW-1:0]   o_idx_reg, o_idx_next;
    logic [DW-1:0]   o_val_reg, o_val_next;
    logic [1:0]      o_status_reg, o_status_next;

    rvm_pkg::rf_rd_t    rf_rd;
    rvm_pkg::rf_wr_t    rf_wr;
    rvm_pkg::rf_rdata_t rf_rdata;

    logic [DW-1:0]   x_val;
    logic [DW-1:0]   y_val;
    logic            a_ok;
    logic            b_ok;
    logic            c_ok;
    logic            cond_op;
    logic            range_err;
    logic            out_free;

    logic [AW-1:0]   alu_a;
    logic [AW-1:0]   alu_b;
    logic            alu_sub;
    logic [AW-1:0]   alu_res;

    rvm_regfile u_regfile
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rf_rd),
        .wr    (rf_wr),
        .rdata (rf_rdata)
    );

    assign x_val = rf_rdata.data0;
    assign y_val = rf_rdata.data1;

    // Register index range checks.
    assign a_ok = !a_reg[FW-1] && (a_reg < FW'(rvm_pkg::NUM_REGS));
    assign c_ok = !c_reg[FW-1] && (c_reg < FW'(rvm_pkg::NUM_REGS));
    assign b_ok = !b_reg[DW-1] && (b_reg < DW'(rvm_pkg::NUM_REGS));

    assign cond_op = (mode_reg == rvm_pkg::OP_JNLT) || (mode_reg == rvm_pkg::OP_JNEQ);

    // Range error for the indexes each opcode uses.
    always_comb
    begin
        range_err = 1'b0;
        unique case (mode_reg)
            rvm_pkg::OP_CONST:
                range_err = !a_ok;
            rvm_pkg::OP_MOVE, rvm_pkg::OP_JNLT, rvm_pkg::OP_JNEQ:
                range_err = !a_ok || !b_ok;
            rvm_pkg::OP_ADD, rvm_pkg::OP_REM:
                range_err = !a_ok || !b_ok || !c_ok;
            default:
                range_err = 1'b0;
        endcase
    end

    // Read addresses: conditional jumps compare a with b, the others read b and c.
    assign rf_rd.en    = (state_reg == rvm_pkg::S_READ);
    assign rf_rd.addr0 = cond_op ? a_reg[IW-1:0] : b_reg[IW-1:0];
    assign rf_rd.addr1 = cond_op ? b_reg[IW-1:0] : c_reg[IW-1:0];

    assign out_free = !out_valid_reg || !out_stall;

    // Register file write happens as the result is loaded into the output register.
    assign rf_wr.en   = (state_reg == rvm_pkg::S_FINISH) && out_free && res_we_reg;
    assign rf_wr.addr = a_reg[IW-1:0];
    assign rf_wr.data = res_val_reg;

    // Shared adder operand selection for compare, add, negation and division steps.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            rvm_pkg::S_EXEC:
            begin
                if (mode_reg == rvm_pkg::OP_REM)
                begin
                    alu_b   = {{2{x_val[DW-1]}}, x_val};
                    alu_sub = x_val[DW-1];
                end
                else
                begin
                    alu_a   = {{2{x_val[DW-1]}}, x_val};
                    alu_b   = {{2{y_val[DW-1]}}, y_val};
                    alu_sub = (mode_reg == rvm_pkg::OP_JNLT);
                end
            end
            rvm_pkg::S_ABSY:
            begin
                alu_b   = {{2{y_val[DW-1]}}, y_val};
                alu_sub = y_val[DW-1];
            end
            rvm_pkg::S_STEP:
            begin
                alu_a   = {1'b0, rem_reg, num_reg[DW-1]};
                alu_b   = {2'b00, den_reg};
                alu_sub = 1'b1;
            end
            rvm_pkg::S_SIGN:
            begin
                alu_b   = {2'b00, rem_reg};
                alu_sub = neg_reg;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

    // Sequencer next state and datapath updates.
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        mode_next       = mode_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        neg_next        = neg_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        res_delta_next  = res_delta_reg;
        res_halt_next   = res_halt_reg;
        res_we_next     = res_we_reg;
        res_idx_next    = res_idx_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        o_delta_next    = o_delta_reg;
        o_halt_next     = o_halt_reg;
        o_we_next       = o_we_reg;
        o_idx_next      = o_idx_reg;
        o_val_next      = o_val_reg;
        o_status_next   = o_status_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rvm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    a_next     = field_a;
                    b_next     = field_b;
                    c_next     = field_c;
                    state_next = rvm_pkg::S_READ;
                end
            end
            rvm_pkg::S_READ:
            begin
                state_next = rvm_pkg::S_EXEC;
            end
            rvm_pkg::S_EXEC:
            begin
                res_delta_next  = FW'(1);
                res_halt_next   = 1'b0;
                res_we_next     = 1'b0;
                res_idx_next    = '0;
                res_val_next    = '0;
                res_status_next = rvm_pkg::ST_OK;
                state_next      = rvm_pkg::S_FINISH;
                if (range_err)
                begin
                    res_status_next = rvm_pkg::ST_RANGE;
                end
                else
                begin
                    unique case (mode_reg)
                        rvm_pkg::OP_CONST:
                        begin
                            res_we_next  = 1'b1;
                            res_idx_next = a_reg[OW-1:0];
                            res_val_next = b_reg;
                        end
                        rvm_pkg::OP_MOVE:
                        begin
                            res_we_next  = 1'b1;
                            res_idx_next = a_reg[OW-1:0];
                            res_val_next = x_val;
                        end
                        rvm_pkg::OP_JUMP:
                        begin
                            res_delta_next = a_reg;
                        end
                        rvm_pkg::OP_JNLT:
                        begin
                            if (!alu_res[AW-1])
                            begin
                                res_delta_next = c_reg;
                            end
                        end
                        rvm_pkg::OP_JNEQ:
                        begin
                            if (x_val != y_val)
                            begin
                                res_delta_next = c_reg;
                            end
                        end
                        rvm_pkg::OP_ADD:
                        begin
                            res_we_next  = 1'b1;
                            res_idx_next = a_reg[OW-1:0];
                            res_val_next = alu_res[DW-1:0];
                        end
                        rvm_pkg::OP_REM:
                        begin
                            if (y_val == '0)
                            begin
                                res_status_next = rvm_pkg::ST_DIVZERO;
                            end
                            else
                            begin
                                num_next   = alu_res[DW-1:0];
                                neg_next   = x_val[DW-1];
                                state_next = rvm_pkg::S_ABSY;
                            end
                        end
                        rvm_pkg::OP_END:
                        begin
                            res_halt_next  = 1'b1;
                            res_delta_next = '0;
                        end
                        default:
                        begin
                            res_delta_next = FW'(1);
                        end
                    endcase
                end
            end
            rvm_pkg::S_ABSY:
            begin
                den_next   = alu_res[DW-1:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = rvm_pkg::S_STEP;
            end
            rvm_pkg::S_STEP:
            begin
                // One restoring division step: keep the difference when it is not negative.
                if (!alu_res[AW-1])
                begin
                    rem_next = alu_res[DW-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[DW-2:0], num_reg[DW-1]};
                end
                num_next = {num_reg[DW-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = rvm_pkg::S_SIGN;
                end
            end
            rvm_pkg::S_SIGN:
            begin
                // The remainder takes the sign of the dividend.
                res_we_next  = 1'b1;
                res_idx_next = a_reg[OW-1:0];
                res_val_next = alu_res[DW-1:0];
                state_next   = rvm_pkg::S_FINISH;
            end
            rvm_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    o_delta_next   = res_delta_reg;
                    o_halt_next    = res_halt_reg;
                    o_we_next      = res_we_reg;
                    o_idx_next     = res_idx_reg;
                    o_val_next     = res_val_reg;
                    o_status_next  = res_status_reg;
                    out_valid_next = 1'b1;
                    state_next     = rvm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rvm_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rvm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        neg_reg        <= neg_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        res_delta_reg  <= res_delta_next;
        res_halt_reg   <= res_halt_next;
        res_we_reg     <= res_we_next;
        res_idx_reg    <= res_idx_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        o_delta_reg    <= o_delta_next;
        o_halt_reg     <= o_halt_next;
        o_we_reg       <= o_we_next;
        o_idx_reg      <= o_idx_next;
        o_val_reg      <= o_val_next;
        o_status_reg   <= o_status_next;
    end

    // Port drive.
    assign in_stall     = (state_reg != rvm_pkg::S_IDLE);
    assign out_valid    = out_valid_reg;
    assign pc_delta     = o_delta_reg;
    assign halted       = o_halt_reg;
    assign write_enable = o_we_reg;
    assign write_index  = o_idx_reg;
    assign write_value  = o_val_reg;
    assign status       = o_status_reg;

`ifndef SYNTHESIS
    // A register write is only reported with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> status == rvm_pkg::ST_OK)
        else $error("write reported with an error status");

    // An end instruction neither steps nor writes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |-> pc_delta == 16'sd0 && !write_enable)
        else $error("halted result steps or writes");

    // After a word is accepted the input stalls while it executes.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // The division loop runs its full count before the sign fixup.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rvm_pkg::S_STEP && cnt_reg != CNT_LAST |=> state_reg == rvm_pkg::S_STEP)
        else $error("division loop left early");

    // The register file is written only as a result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |=> out_valid && write_enable)
        else $error("register write without a matching result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/rvm_regfile.sv
// Register file memory with two registered read ports and per-entry valid bits.
`default_nettype none

module rvm_regfile
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rvm_pkg::rf_rd_t    rd,
    input  wire rvm_pkg::rf_wr_t    wr,
    output rvm_pkg::rf_rdata_t      rdata
);

    logic [rvm_pkg::DATA_W-1:0]   mem_reg [rvm_pkg::NUM_REGS];
    logic [rvm_pkg::NUM_REGS-1:0] vld_reg;
    logic [rvm_pkg::DATA_W-1:0]   d0_reg;
    logic [rvm_pkg::DATA_W-1:0]   d1_reg;
    logic                         v0_reg;
    logic                         v1_reg;

    // Memory write and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            d0_reg <= mem_reg[rd.addr0];
            d1_reg <= mem_reg[rd.addr1];
        end
    end

    // Valid bits mark entries written since reset; others read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                v0_reg <= vld_reg[rd.addr0];
                v1_reg <= vld_reg[rd.addr1];
            end
        end
    end

    // Entries never written since reset read as zero.
    assign rdata.data0 = v0_reg ? d0_reg : '0;
    assign rdata.data1 = v1_reg ? d1_reg : '0;

endmodule

`default_nettype wire
